FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

FILE: hdl/kdlpr_pkg.sv
// ---------------------------------------------------------------------------
// kdlpr_pkg
// Types and constants of the key debounce / long press / repeat block.
// ---------------------------------------------------------------------------
package kdlpr_pkg;

   localparam int KEYS  = 4;
   localparam int KEY_W = 2;

   typedef enum logic [1:0] {
      EVT_NONE   = 2'd0,
      EVT_SHORT  = 2'd1,
      EVT_LONG   = 2'd2,
      EVT_REPEAT = 2'd3
   } evt_type_type;

   typedef enum logic [1:0] {
      CSR_DEBOUNCE  = 2'd0,
      CSR_LONG      = 2'd1,
      CSR_REPEAT    = 2'd2,
      CSR_PRESS_LVL = 2'd3
   } csr_index_type;

   localparam logic [3:0] DEBOUNCE_RST  = 4'd3;
   localparam logic [7:0] LONG_RST      = 8'd60;
   localparam logic [7:0] REPEAT_RST    = 8'd12;
   localparam logic       PRESS_LVL_RST = 1'b0;

   typedef struct packed {
      logic [3:0] debounce_samples;
      logic [7:0] long_press_ticks;
      logic [7:0] repeat_ticks;
      logic       pressed_level;
   } cfg_type;

   typedef struct packed {
      logic       last_raw;
      logic       stable;
      logic [3:0] db_count;
      logic [7:0] hold_count;
      logic [7:0] repeat_count;
      logic       long_sent;
   } key_state_type;

   typedef struct packed {
      evt_type_type     event_type;
      logic [KEY_W-1:0] event_key;
   } rsp_type;

endpackage

FILE: hdl/kdlpr_key_cell.sv
// ---------------------------------------------------------------------------
// kdlpr_key_cell
// Per-key debounce, hold and repeat counters; flags at most one event per tick.
// ---------------------------------------------------------------------------
module kdlpr_key_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       enable,
   input  logic                       level,
   input  kdlpr_pkg::cfg_type         cfg,
   output kdlpr_pkg::evt_type_type    evt
);
   import kdlpr_pkg::*;

   key_state_type state_ff;
   key_state_type state_in;
   logic          raw;
   logic [8:0]    hold;
   logic [8:0]    rep;

   always_comb begin
      raw      = (level == cfg.pressed_level);
      state_in = state_ff;
      evt      = EVT_NONE;
      hold     = 9'd0;
      rep      = 9'd0;
      if (raw != state_ff.last_raw) begin
         // restart debounce on any change of the raw view
         state_in.last_raw = raw;
         state_in.db_count = 4'd1;
      end else if (state_ff.db_count < cfg.debounce_samples) begin
         state_in.db_count = state_ff.db_count + 4'd1;
      end else begin
         if (raw != state_ff.stable) begin
            state_in.stable = raw;
            if (!raw && !state_ff.long_sent) begin
               evt = EVT_SHORT;
            end
            state_in.hold_count   = 8'd0;
            state_in.repeat_count = 8'd0;
            state_in.long_sent    = 1'b0;
         end
         if (state_in.stable) begin
            hold = (state_in.hold_count == 8'hFF) ? 9'd255
                                                  : {1'b0, state_in.hold_count} + 9'd1;
            if (!state_in.long_sent && hold >= {1'b0, cfg.long_press_ticks}) begin
               state_in.long_sent    = 1'b1;
               state_in.repeat_count = 8'd0;
               evt                   = EVT_LONG;
            end else if (state_in.long_sent) begin
               rep = {1'b0, state_in.repeat_count} + 9'd1;
               if (rep >= {1'b0, cfg.repeat_ticks}) begin
                  rep = 9'd0;
                  evt = EVT_REPEAT;
               end
               state_in.repeat_count = rep[7:0];
            end
            // saturate hold at the long-press threshold
            if (hold > {1'b0, cfg.long_press_ticks}) begin
               hold = {1'b0, cfg.long_press_ticks};
            end
            state_in.hold_count = hold[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (enable) begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/kdlpr_out_stage.sv
// ---------------------------------------------------------------------------
// kdlpr_out_stage
// Result register plus a skid entry for a load that meets a stalled output.
// ---------------------------------------------------------------------------
module kdlpr_out_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  kdlpr_pkg::rsp_type data,
   output logic               full,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output kdlpr_pkg::rsp_type rsp_data
);
   import kdlpr_pkg::*;

   logic    out_valid_ff;
   logic    skid_valid_ff;
   rsp_type out_data_ff;
   rsp_type skid_data_ff;
   logic    out_free;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // drain skid entry first; no load can arrive while it is full
         if (out_free) begin
            skid_valid_ff <= 1'b0;
            out_valid_ff  <= 1'b1;
         end
      end else if (load) begin
         if (out_free) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_free) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_free) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (load) begin
         if (out_free) begin
            out_data_ff <= data;
         end else begin
            skid_data_ff <= data;
         end
      end
   end

endmodule

FILE: hdl/key_debounce_long_press_repeat_core.sv
// ---------------------------------------------------------------------------
// key_debounce_long_press_repeat_core
// Debounces KEYS inputs per scan tick and reports short, long and repeat
// events of the lowest-numbered key that has one.
// ---------------------------------------------------------------------------
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_key_levels[3:0]
//   rsp_      out        rsp_valid/rsp_stall  rsp_event_type[1:0], rsp_event_key[1:0]
//   csr_      in         csr_wr_en            csr_index[1:0], csr_wdata[7:0]
//
// One transaction per cycle while req_stall is low: all key cells update at the
// end of the accept cycle, and its result is registered at the same edge into the
// output register, or into the skid entry behind it when the output is stalled;
// req_stall rises only when both entries hold data.
// Synchronous reset clears all key state and loads the default settings.
// ---------------------------------------------------------------------------
module key_debounce_long_press_repeat_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [3:0]                req_key_levels,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output kdlpr_pkg::evt_type_type   rsp_event_type,
   output logic [kdlpr_pkg::KEY_W-1:0] rsp_event_key,
   input  logic                      csr_wr_en,
   input  kdlpr_pkg::csr_index_type  csr_index,
   input  logic [7:0]                csr_wdata
);
   import kdlpr_pkg::*;

   cfg_type      cfg_ff;
   logic         accept;
   logic         full;
   evt_type_type key_evt [KEYS];
   rsp_type      pick;
   rsp_type      rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_samples <= DEBOUNCE_RST;
         cfg_ff.long_press_ticks <= LONG_RST;
         cfg_ff.repeat_ticks     <= REPEAT_RST;
         cfg_ff.pressed_level    <= PRESS_LVL_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DEBOUNCE:  cfg_ff.debounce_samples <= csr_wdata[3:0];
            CSR_LONG:      cfg_ff.long_press_ticks <= csr_wdata;
            CSR_REPEAT:    cfg_ff.repeat_ticks     <= csr_wdata;
            CSR_PRESS_LVL: cfg_ff.pressed_level    <= csr_wdata[0];
            default:       ;
         endcase
      end
   end

   assign req_stall = full;
   assign accept    = req_valid && !full;

   for (genvar k = 0; k < KEYS; k++) begin : g_key
      kdlpr_key_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .enable (accept),
         .level  (req_key_levels[k]),
         .cfg    (cfg_ff),
         .evt    (key_evt[k])
      );
   end

   // lowest-numbered key wins; scan from the top so it overrides
   always_comb begin
      pick.event_type = EVT_NONE;
      pick.event_key  = '0;
      for (int i = KEYS - 1; i >= 0; i--) begin
         if (key_evt[i] != EVT_NONE) begin
            pick.event_type = key_evt[i];
            pick.event_key  = KEY_W'(i);
         end
      end
   end

   kdlpr_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .data      (pick),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_event_type = rsp_data.event_type;
   assign rsp_event_key  = rsp_data.event_key;

endmodule

FILE: hdl/kdlpr_checker.sv
// ---------------------------------------------------------------------------
// kdlpr_checker
// Port-level checks of the key debounce core, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module kdlpr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_event_type,
   input logic [1:0] rsp_event_key
);
   import kdlpr_pkg::*;

   logic accept;
   assign accept = req_valid && !req_stall;

   // hold a stalled result
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_event_type) && $stable(rsp_event_key))
   // no event means key zero
   `ASSERT_IMPLY(a_none_key0, clock, reset, rsp_valid && rsp_event_type == EVT_NONE, rsp_event_key == '0)
   // rsp_valid is high in the cycle after every accepted transaction
   `ASSERT_NEXT(a_accept_out, clock, reset, accept, rsp_valid)
   // input backpressure only with a result pending
   `ASSERT_IMPLY(a_stall_pending, clock, reset, req_stall, rsp_valid)

endmodule

bind key_debounce_long_press_repeat_core kdlpr_checker u_kdlpr_checker (.*);

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Checks the key debounce / long press / repeat core against a scan-by-scan
// prediction of every key's debounce, hold and repeat counters. Settings are
// rewritten between phases while the core is idle; key activity is mostly
// press/hold/release sequences with chatter, with a phase of raw noise.
// Both channels idle at random, with one back-to-back phase.
// ---------------------------------------------------------------------------
module testbench;
   import kdlpr_pkg::*;

   logic            clock;
   logic            reset          = 1'b1;
   logic            req_valid      = 1'b0;
   logic            req_stall;
   logic [3:0]      req_key_levels = 4'h0;
   logic            rsp_valid;
   logic            rsp_stall      = 1'b0;
   evt_type_type    rsp_event_type;
   logic [KEY_W-1:0] rsp_event_key;
   logic            csr_wr_en      = 1'b0;
   csr_index_type   csr_index      = CSR_DEBOUNCE;
   logic [7:0]      csr_wdata      = 8'h00;

   key_debounce_long_press_repeat_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_key_levels (req_key_levels),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_event_type (rsp_event_type),
      .rsp_event_key  (rsp_event_key),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // predicted settings and per-key state
   logic [3:0] deb_samples;
   logic [7:0] long_ticks;
   logic [7:0] rep_ticks;
   logic       press_lvl;
   logic       key_last_raw  [KEYS];
   logic       key_stable    [KEYS];
   logic [3:0] key_db_count  [KEYS];
   logic [7:0] key_hold      [KEYS];
   logic [7:0] key_repeat    [KEYS];
   logic       key_long_sent [KEYS];

   rsp_type expected_events [$];
   rsp_type want;
   int      mismatches   = 0;
   int      scans_sent   = 0;
   int      results_seen = 0;
   bit      steady       = 1'b0;

   // settings as the stimulus sees them
   int set_deb  = DEBOUNCE_RST;
   int set_long = LONG_RST;
   int set_rep  = REPEAT_RST;
   int set_lvl  = PRESS_LVL_RST;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      if (mismatches < 20)
         $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
   endtask

   function automatic void reset_keys();
      deb_samples = DEBOUNCE_RST;
      long_ticks  = LONG_RST;
      rep_ticks   = REPEAT_RST;
      press_lvl   = PRESS_LVL_RST;
      for (int k = 0; k < KEYS; k++) begin
         key_last_raw[k]  = 1'b0;
         key_stable[k]    = 1'b0;
         key_db_count[k]  = 4'd0;
         key_hold[k]      = 8'd0;
         key_repeat[k]    = 8'd0;
         key_long_sent[k] = 1'b0;
      end
   endfunction

   function automatic void write_setting(input csr_index_type idx, input logic [7:0] data);
      case (idx)
         CSR_DEBOUNCE:  deb_samples = data[3:0];
         CSR_LONG:      long_ticks  = data;
         CSR_REPEAT:    rep_ticks   = data;
         CSR_PRESS_LVL: press_lvl   = data[0];
         default: ;
      endcase
   endfunction

   // advance every key by one scan tick; the lowest key with an event wins
   function automatic rsp_type predict_event(input logic [3:0] levels);
      rsp_type     ev;
      logic        raw;
      logic        found;
      int unsigned held;
      int unsigned rep;
      ev.event_type = EVT_NONE;
      ev.event_key  = '0;
      found = 1'b0;
      for (int k = 0; k < KEYS; k++) begin
         raw = (levels[k] == press_lvl);
         if (raw != key_last_raw[k]) begin
            key_last_raw[k] = raw;
            key_db_count[k] = 4'd1;
         end else if (key_db_count[k] < deb_samples) begin
            key_db_count[k] = key_db_count[k] + 4'd1;
         end else begin
            if (raw != key_stable[k]) begin
               key_stable[k] = raw;
               if (!raw && !key_long_sent[k] && !found) begin
                  ev.event_type = EVT_SHORT;
                  ev.event_key  = KEY_W'(k);
                  found = 1'b1;
               end
               key_hold[k]      = 8'd0;
               key_repeat[k]    = 8'd0;
               key_long_sent[k] = 1'b0;
            end
            if (key_stable[k]) begin
               held = (key_hold[k] < 8'd255) ? key_hold[k] + 1 : 255;
               if (!key_long_sent[k] && held >= long_ticks) begin
                  key_long_sent[k] = 1'b1;
                  key_repeat[k]    = 8'd0;
                  if (!found) begin
                     ev.event_type = EVT_LONG;
                     ev.event_key  = KEY_W'(k);
                     found = 1'b1;
                  end
               end else if (key_long_sent[k]) begin
                  rep = key_repeat[k] + 1;
                  if (rep >= rep_ticks) begin
                     rep = 0;
                     if (!found) begin
                        ev.event_type = EVT_REPEAT;
                        ev.event_key  = KEY_W'(k);
                        found = 1'b1;
                     end
                  end
                  key_repeat[k] = rep[7:0];
               end
               // hold time saturates at the long-press threshold
               if (held > long_ticks)
                  held = long_ticks;
               key_hold[k] = held[7:0];
            end
         end
      end
      return ev;
   endfunction

   // check results, track settings, predict each accepted scan
   always @(posedge clock) begin
      if (reset) begin
         reset_keys();
         expected_events.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_events.size() == 0) begin
               report_mismatch($sformatf("unexpected result: type %0d key %0d",
                                         rsp_event_type, rsp_event_key));
            end else begin
               want = expected_events.pop_front();
               if (rsp_event_type !== want.event_type)
                  report_mismatch($sformatf("event_type %0d, expected %0d (key %0d)",
                                            rsp_event_type, want.event_type,
                                            want.event_key));
               if (rsp_event_key !== want.event_key)
                  report_mismatch($sformatf("event_key %0d, expected %0d (type %0d)",
                                            rsp_event_key, want.event_key,
                                            want.event_type));
            end
         end
         if (csr_wr_en)
            write_setting(csr_index, csr_wdata);
         if (req_valid && !req_stall)
            expected_events.push_back(predict_event(req_key_levels));
      end
   end

   // mostly short gaps, a few long ones, none while steady
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 50)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   initial begin
      int n;
      wait (!reset);
      forever begin
         n = pick_gap();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat (pick_gap() + 1) @(posedge clock);
      end
   end

   // send one scan transaction; valid stays high into the next one when no gap
   task automatic send_scan(input logic [3:0] levels);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_key_levels <= levels;
      do
         @(posedge clock);
      while (req_stall);
      scans_sent++;
   endtask

   // wait until every accepted scan has produced its result
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (results_seen != scans_sent)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_settings(input int deb, input int lp, input int rep, input int lvl);
      wait_idle();
      // upper data bits are don't-care for the narrow registers
      csr_wr_en <= 1'b1;
      csr_index <= CSR_DEBOUNCE;
      csr_wdata <= 8'(deb) | 8'($urandom_range(0, 15) << 4);
      @(posedge clock);
      csr_index <= CSR_LONG;
      csr_wdata <= 8'(lp);
      @(posedge clock);
      csr_index <= CSR_REPEAT;
      csr_wdata <= 8'(rep);
      @(posedge clock);
      csr_index <= CSR_PRESS_LVL;
      csr_wdata <= 8'(lvl) | 8'($urandom_range(0, 127) << 1);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      set_deb  = deb & 15;
      set_long = lp & 255;
      set_rep  = rep & 255;
      set_lvl  = lvl & 1;
   endtask

   // one burst of key activity: each key pressed over its window, if not empty,
   // with chatter around the edges, then everything released long enough
   task automatic play_keys();
      int         start_t [KEYS];
      int         stop_t  [KEYS];
      int         span;
      int         hold_max;
      int         len;
      logic [3:0] pressed;
      hold_max = set_long + 2 * set_rep + set_deb + 4;
      span = 0;
      for (int k = 0; k < KEYS; k++) begin
         start_t[k] = $urandom_range(0, 6);
         case ($urandom_range(0, 3))
            0:       len = 0;
            1:       len = $urandom_range(1, set_deb + set_long / 2 + 2);
            default: len = $urandom_range(1, hold_max);
         endcase
         stop_t[k] = start_t[k] + len;
         if (stop_t[k] > span)
            span = stop_t[k];
      end
      span = span + set_deb + 3;
      for (int t = 0; t < span; t++) begin
         for (int k = 0; k < KEYS; k++) begin
            pressed[k] = (t >= start_t[k]) && (t < stop_t[k]);
            if (stop_t[k] > start_t[k] && $urandom_range(0, 2) == 0 &&
                ((t - start_t[k] < 2 && start_t[k] - t < 2) ||
                 (t - stop_t[k] < 2 && stop_t[k] - t < 2)))
               pressed[k] = ~pressed[k];
         end
         send_scan(set_lvl ? pressed : ~pressed);
      end
   endtask

   task automatic run_presses(input int budget);
      int mark;
      mark = scans_sent;
      while (scans_sent - mark < budget)
         play_keys();
   endtask

   task automatic test_reset_defaults();
      run_presses(250);
   endtask

   // zero debounce, long press and repeat; then a short press and a held key
   task automatic test_directed();
      logic [3:0] seq_zero  [12] = '{4'h0, 4'hF, 4'hF, 4'hF, 4'hE, 4'hE,
                                     4'hC, 4'h0, 4'h0, 4'h8, 4'h8, 4'h0};
      logic [3:0] seq_short [12] = '{4'hF, 4'hE, 4'hE, 4'hF, 4'hF, 4'hE,
                                     4'hE, 4'hE, 4'hE, 4'hE, 4'hF, 4'hF};
      apply_settings(0, 0, 0, 1);
      foreach (seq_zero[i])
         send_scan(seq_zero[i]);
      apply_settings(1, 2, 1, 0);
      foreach (seq_short[i])
         send_scan(seq_short[i]);
   endtask

   task automatic test_low_extremes();
      apply_settings(0, 0, 0, 1);
      run_presses(150);
   endtask

   task automatic test_high_extremes();
      apply_settings(15, 255, 255, 0);
      run_presses(200);
   endtask

   task automatic test_back_to_back();
      steady = 1'b1;
      apply_settings(1, 1, 1, 1);
      run_presses(150);
      wait_idle();
      steady = 1'b0;
   endtask

   task automatic test_random_settings();
      repeat (4) begin
         apply_settings($urandom_range(0, 4), $urandom_range(0, 24),
                        $urandom_range(0, 8), $urandom_range(0, 1));
         run_presses(90);
      end
   endtask

   task automatic test_raw_noise();
      apply_settings($urandom_range(0, 2), $urandom_range(0, 6),
                     $urandom_range(0, 3), $urandom_range(0, 1));
      repeat (150)
         send_scan(4'($urandom_range(0, 15)));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed();
      test_low_extremes();
      test_high_extremes();
      test_back_to_back();
      test_random_settings();
      test_raw_noise();
      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
